// ===== rtl/knn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_pkg
// shared constants, types and helpers of the streaming k-nearest-neighbor block
// ----------------------------------------------------------------------------
package knn_pkg;

    // table depth and derived widths
    localparam int MaxNeighbors = 16;
    localparam int IdxW         = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;
    localparam int CntW         = $clog2(MaxNeighbors + 1);

    // field widths
    localparam int IdW    = 48;
    localparam int CoordW = 30;
    localparam int SqW    = 2 * CoordW;
    localparam int DistW  = SqW + 1;
    localparam int SumW   = 64;
    localparam int NcW    = 5;
    localparam int KW     = (CntW > NcW) ? CntW : NcW;

    // stream packing
    localparam int SDataW = ((IdW + 2 * CoordW + 7) / 8) * 8;
    localparam int MDataW = ((IdW + DistW + SumW + 7) / 8) * 8;

    // apb
    localparam int PaddrW = 4;
    localparam int PdataW = 32;
    localparam logic [1:0] RegQueryX   = 2'd0;
    localparam logic [1:0] RegQueryY   = 2'd1;
    localparam logic [1:0] RegNbrCount = 2'd2;
    localparam logic [NcW-1:0] NbrCountReset = NcW'(10);

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic sq_x;
        logic sq_y;
        logic add;
        logic insert;
        logic emit_beat;
    } knn_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_point;
        logic emit_last;
        logic out_free;
    } knn_stat_t;

    // effective k: zero counts as one, clamp at table depth
    function automatic logic [CntW-1:0] eff_k(input logic [NcW-1:0] nc);
        logic [KW-1:0] ncx;
        ncx = KW'(nc);
        if (nc == '0) begin
            return CntW'(1);
        end else if (ncx > KW'(MaxNeighbors)) begin
            return CntW'(MaxNeighbors);
        end else begin
            return CntW'(ncx);
        end
    endfunction

endpackage

// ===== rtl/streaming_knn_topk_select_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_knn_topk_select_top
// brute-force k nearest neighbors over a point stream, apb configured
// ----------------------------------------------------------------------------
// Each point beat passes in turn through accept, square dx, square dy, add and
// sorted insert; one multiplier is shared by both squares.
// s_tready is high only between points. On a beat with s_tlast the kept
// neighbors follow on m_*, worst first, one beat per cycle while m_tready is
// high; m_tlast marks the final beat, which alone carries the id sum. The next
// point is taken as soon as the final beat sits in the output register. No
// clearing pass follows reset.
module streaming_knn_topk_select_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // point stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // point_id[47:0], point_x[77:48], point_y[107:78], zero fill
    input  logic [knn_pkg::SDataW-1:0]         s_tdata,
    input  logic                               s_tlast,
    // neighbor stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // neighbor_id[47:0], neighbor_dist[108:48], id_sum[172:109], zero fill
    output logic [knn_pkg::MDataW-1:0]         m_tdata,
    output logic                               m_tlast,
    // apb configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [knn_pkg::PaddrW-1:0]         paddr,
    input  logic [knn_pkg::PdataW-1:0]         pwdata,
    output logic [knn_pkg::PdataW-1:0]         prdata,
    output logic                               pready
);

    localparam int IdW    = knn_pkg::IdW;
    localparam int CoordW = knn_pkg::CoordW;
    localparam int DistW  = knn_pkg::DistW;
    localparam int SumW   = knn_pkg::SumW;

    logic [CoordW-1:0]       qx_reg;
    logic [CoordW-1:0]       qy_reg;
    logic [knn_pkg::NcW-1:0] nc_reg;
    logic                    cfg_we;
    logic [1:0]              reg_sel;

    knn_pkg::knn_cmd_t  cmd;
    knn_pkg::knn_stat_t stat;

    logic [IdW-1:0]   neighbor_id;
    logic [DistW-1:0] neighbor_dist;
    logic [SumW-1:0]  id_sum;

    // register file
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg <= '0;
            qy_reg <= '0;
            nc_reg <= knn_pkg::NbrCountReset;
        end else if (cfg_we) begin
            case (reg_sel)
                knn_pkg::RegQueryX:   qx_reg <= pwdata[CoordW-1:0];
                knn_pkg::RegQueryY:   qy_reg <= pwdata[CoordW-1:0];
                knn_pkg::RegNbrCount: nc_reg <= pwdata[knn_pkg::NcW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            knn_pkg::RegQueryX:   prdata = knn_pkg::PdataW'(qx_reg);
            knn_pkg::RegQueryY:   prdata = knn_pkg::PdataW'(qy_reg);
            knn_pkg::RegNbrCount: prdata = knn_pkg::PdataW'(nc_reg);
            default:              prdata = '0;
        endcase
    end

    // controller
    knn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    knn_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .query_x        (qx_reg),
        .query_y        (qy_reg),
        .neighbor_count (nc_reg),
        .point_id       (s_tdata[IdW-1:0]),
        .point_x        (s_tdata[IdW+CoordW-1:IdW]),
        .point_y        (s_tdata[IdW+2*CoordW-1:IdW+CoordW]),
        .last_point     (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .neighbor_id    (neighbor_id),
        .neighbor_dist  (neighbor_dist),
        .id_sum         (id_sum),
        .final_result   (m_tlast)
    );

    // result packing
    assign m_tdata = knn_pkg::MDataW'({id_sum, neighbor_dist, neighbor_id});

endmodule

// ===== rtl/knn_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_ctrl
// sequencer: accept a point, square both deltas, add, insert, emit on last
// ----------------------------------------------------------------------------
module knn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  knn_pkg::knn_stat_t stat,
    output knn_pkg::knn_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQX  = 6'b000010,
        ST_SQY  = 6'b000100,
        ST_ADD  = 6'b001000,
        ST_INS  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sq_y   = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_INS;
            end
            ST_INS: begin
                cmd.insert = 1'b1;
                state_next = stat.last_point ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                cmd.emit_beat = stat.out_free;
                if (stat.out_free && stat.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/knn_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_dp
// distance datapath, sorted neighbor table and result beat register
// ----------------------------------------------------------------------------
module knn_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  knn_pkg::knn_cmd_t                 cmd,
    output knn_pkg::knn_stat_t                stat,
    input  logic [knn_pkg::CoordW-1:0]        query_x,
    input  logic [knn_pkg::CoordW-1:0]        query_y,
    input  logic [knn_pkg::NcW-1:0]           neighbor_count,
    input  logic [knn_pkg::IdW-1:0]           point_id,
    input  logic [knn_pkg::CoordW-1:0]        point_x,
    input  logic [knn_pkg::CoordW-1:0]        point_y,
    input  logic                              last_point,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [knn_pkg::IdW-1:0]           neighbor_id,
    output logic [knn_pkg::DistW-1:0]         neighbor_dist,
    output logic [knn_pkg::SumW-1:0]          id_sum,
    output logic                              final_result
);

    localparam int N = knn_pkg::MaxNeighbors;

    // point pipeline registers
    logic [knn_pkg::IdW-1:0]    id_reg;
    logic                       last_reg;
    logic [knn_pkg::CoordW-1:0] dx_reg;
    logic [knn_pkg::CoordW-1:0] dy_reg;
    logic [knn_pkg::SqW-1:0]    sqx_reg;
    logic [knn_pkg::SqW-1:0]    sqy_reg;
    logic [knn_pkg::DistW-1:0]  dist_reg;

    // neighbor table, kept nearest first
    logic [knn_pkg::IdW-1:0]    ids_reg   [N];
    logic [knn_pkg::DistW-1:0]  dists_reg [N];
    logic [knn_pkg::CntW-1:0]   cnt_reg;
    logic [knn_pkg::CntW-1:0]   cnt_next;

    // emission
    logic [knn_pkg::IdxW-1:0]   idx_reg;
    logic [knn_pkg::SumW-1:0]   sum_reg;
    logic                       m_valid_reg;
    logic [knn_pkg::IdW-1:0]    m_id_reg;
    logic [knn_pkg::DistW-1:0]  m_dist_reg;
    logic [knn_pkg::SumW-1:0]   m_sum_reg;
    logic                       m_last_reg;

    logic [knn_pkg::CoordW-1:0] mul_a;
    logic [knn_pkg::SqW-1:0]    prod;
    logic [knn_pkg::CntW-1:0]   k_eff;
    logic [knn_pkg::CntW-1:0]   c_eff;
    logic [N-1:0]               nearer;
    logic [N-1:0]               at_pos;
    logic [N-1:0]               in_k;
    logic                       inserted;
    logic [knn_pkg::IdW-1:0]    new_id   [N];
    logic [knn_pkg::DistW-1:0]  new_dist [N];
    logic [knn_pkg::IdW-1:0]    rd_id;
    logic [knn_pkg::SumW-1:0]   sum_plus;
    logic                       out_free;

    // shared squaring multiplier
    assign mul_a = cmd.sq_y ? dy_reg : dx_reg;
    assign prod  = knn_pkg::SqW'(mul_a) * knn_pkg::SqW'(mul_a);

    // capture, abs deltas, squares, sum
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            id_reg   <= point_id;
            last_reg <= last_point;
            dx_reg   <= (point_x >= query_x) ? point_x - query_x : query_x - point_x;
            dy_reg   <= (point_y >= query_y) ? point_y - query_y : query_y - point_y;
        end
        if (cmd.sq_x) begin
            sqx_reg <= prod;
        end
        if (cmd.sq_y) begin
            sqy_reg <= prod;
        end
        if (cmd.add) begin
            dist_reg <= knn_pkg::DistW'(sqx_reg) + knn_pkg::DistW'(sqy_reg);
        end
    end

    // insertion position: compare against every kept entry at once
    always_comb begin
        k_eff = knn_pkg::eff_k(neighbor_count);
        c_eff = (cnt_reg > k_eff) ? k_eff : cnt_reg;
        for (int j = 0; j < N; j++) begin
            nearer[j] = (knn_pkg::CntW'(j) < c_eff) &&
                        ((dist_reg < dists_reg[j]) ||
                         ((dist_reg == dists_reg[j]) && (id_reg > ids_reg[j])));
            in_k[j]   = knn_pkg::CntW'(j) < k_eff;
        end
        for (int j = 0; j < N; j++) begin
            at_pos[j] = ((j == 0) ? 1'b1 : !nearer[(j == 0) ? 0 : j - 1]) &&
                        (nearer[j] || (knn_pkg::CntW'(j) == c_eff));
            if (at_pos[j]) begin
                new_id[j]   = id_reg;
                new_dist[j] = dist_reg;
            end else if ((j > 0) && nearer[(j == 0) ? 0 : j - 1]) begin
                new_id[j]   = ids_reg[(j == 0) ? 0 : j - 1];
                new_dist[j] = dists_reg[(j == 0) ? 0 : j - 1];
            end else begin
                new_id[j]   = ids_reg[j];
                new_dist[j] = dists_reg[j];
            end
        end
        inserted = |(at_pos & in_k);
        if (inserted) begin
            cnt_next = (c_eff < k_eff) ? c_eff + knn_pkg::CntW'(1) : k_eff;
        end else begin
            cnt_next = c_eff;
        end
    end

    // table entries
    always_ff @(posedge aclk) begin
        for (int j = 0; j < N; j++) begin
            if (cmd.insert && inserted && in_k[j]) begin
                ids_reg[j]   <= new_id[j];
                dists_reg[j] <= new_dist[j];
            end
        end
    end

    // emission read and running id sum
    assign rd_id    = ids_reg[idx_reg];
    assign sum_plus = sum_reg + knn_pkg::SumW'(rd_id);
    assign out_free = !m_valid_reg || m_tready;

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.insert) begin
            cnt_reg <= cnt_next;
        end else if (cmd.emit_beat && (idx_reg == '0)) begin
            cnt_reg <= '0;
        end
    end

    // emission index and sum, worst entry first
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            idx_reg <= knn_pkg::IdxW'(cnt_next - knn_pkg::CntW'(1));
            sum_reg <= '0;
        end else if (cmd.emit_beat) begin
            idx_reg <= idx_reg - knn_pkg::IdxW'(1);
            sum_reg <= sum_plus;
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_beat) begin
            m_id_reg   <= rd_id;
            m_dist_reg <= dists_reg[idx_reg];
            m_sum_reg  <= (idx_reg == '0) ? sum_plus : '0;
            m_last_reg <= (idx_reg == '0);
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign neighbor_id   = m_id_reg;
    assign neighbor_dist = m_dist_reg;
    assign id_sum        = m_sum_reg;
    assign final_result  = m_last_reg;

    assign stat.last_point = last_reg;
    assign stat.emit_last  = (idx_reg == '0);
    assign stat.out_free   = out_free;

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= knn_pkg::CntW'(N))
        else $error("neighbor count beyond table depth");

    a_sum_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_last_reg |-> m_sum_reg == '0)
        else $error("id sum on a non-final beat");

    a_empty_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_beat && (idx_reg == '0) |=> cnt_reg == '0)
        else $error("table not emptied after final beat");

    a_beat_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_beat |-> out_free)
        else $error("beat loaded over a waiting result");

endmodule
